### hdl/tsp_pkg.sv
package tsp_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PLAY  = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLED     = 2'd0;
  localparam logic [1:0] CFG_FIRST_SCALE = 2'd1;
  localparam logic [1:0] CFG_NEXT_SCALE  = 2'd2;

  localparam int unsigned IDX_W     = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned ENTRY_W   = 2 * CODE_W;
  localparam int unsigned HZ_W      = 16;
  localparam int unsigned ELAPSED_W = 13;

  localparam logic [CODE_W-1:0]    HOLD_CODE   = 8'd255;
  localparam logic [ELAPSED_W-1:0] STEP_MS     = 13'd20;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 13'd8191;

  localparam logic [CODE_W-1:0] FIRST_SCALE_RST = 8'd60;
  localparam logic [CODE_W-1:0] NEXT_SCALE_RST  = 8'd75;

  typedef struct packed {
    op_e                operation;
    logic [IDX_W-1:0]   entry_index;
    logic [CODE_W-1:0]  tone_frequency_code;
    logic [CODE_W-1:0]  tone_time_code;
    logic [COUNT_W-1:0] tone_count;
    logic               repeat_flag;
  } tsp_in_t;

  typedef struct packed {
    logic [HZ_W-1:0]  tone_hz;
    logic             sound_on;
    logic             playing;
    logic [IDX_W-1:0] tone_position;
  } tsp_out_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] data;
  } tsp_tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [1:0]        index;
    logic [CODE_W-1:0] data;
  } tsp_cfg_wr_t;

endpackage

### hdl/tsp_table.sv
module tsp_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  tsp_pkg::tsp_tbl_wr_t               wr_i,
  input  logic [tsp_pkg::COUNT_W-1:0]        rd_idx_i,
  output logic [tsp_pkg::ENTRY_W-1:0]        rd_data_o,
  output logic [tsp_pkg::ENTRY_W-1:0]        entry0_o
);

  // the write index is four bits wide, so no more than sixteen entries can hold data
  localparam int unsigned StoreDepth = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;
  localparam int unsigned SelW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic [tsp_pkg::ENTRY_W-1:0] mem [StoreDepth];
  logic                        wr_hit;
  logic                        rd_hit;

  assign wr_hit = ({1'b0, wr_i.idx} < tsp_pkg::COUNT_W'(StoreDepth));
  assign rd_hit = (rd_idx_i < tsp_pkg::COUNT_W'(StoreDepth));

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_hit) begin
      mem[wr_i.idx[SelW-1:0]] <= wr_i.data;
    end
  end

  // entries past the table read as zero
  assign rd_data_o = rd_hit ? mem[rd_idx_i[SelW-1:0]] : '0;
  assign entry0_o  = mem[0];

endmodule

### hdl/tsp_core.sv
module tsp_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  tsp_pkg::tsp_in_t              req_i,
  input  tsp_pkg::tsp_cfg_wr_t          cfg_i,
  input  logic [tsp_pkg::ENTRY_W-1:0]   tbl_rd_data_i,
  input  logic [tsp_pkg::ENTRY_W-1:0]   tbl_entry0_i,
  output logic [tsp_pkg::COUNT_W-1:0]   tbl_rd_idx_o,
  output tsp_pkg::tsp_tbl_wr_t          tbl_wr_o,
  output tsp_pkg::tsp_out_t             res_o
);

  logic                            enabled_q;
  logic [tsp_pkg::CODE_W-1:0]      first_scale_q;
  logic [tsp_pkg::CODE_W-1:0]      next_scale_q;

  logic [tsp_pkg::COUNT_W-1:0]     idx_q,     idx_d;
  logic [tsp_pkg::COUNT_W-1:0]     len_q,     len_d;
  logic                            rep_q,     rep_d;
  logic                            active_q,  active_d;
  logic [tsp_pkg::ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic [tsp_pkg::HZ_W-1:0]        hz_q,      hz_d;
  logic                            on_q,      on_d;
  // time code of the entry now sounding
  logic [tsp_pkg::CODE_W-1:0]      tc_q,      tc_d;

  logic [tsp_pkg::COUNT_W-1:0]     nxt_idx;
  logic                            wrap;
  logic [tsp_pkg::ELAPSED_W-1:0]   el_inc;
  logic [tsp_pkg::ELAPSED_W-1:0]   limit;
  logic                            cfg_halt;

  assign nxt_idx      = idx_q + tsp_pkg::COUNT_W'(1);
  assign wrap         = (nxt_idx >= len_q);
  assign tbl_rd_idx_o = wrap ? '0 : nxt_idx;

  assign el_inc = (elapsed_q < tsp_pkg::ELAPSED_MAX) ? elapsed_q + tsp_pkg::ELAPSED_W'(1)
                                                     : elapsed_q;
  assign limit  = (tsp_pkg::ELAPSED_W'(tc_q) + tsp_pkg::ELAPSED_W'(1)) * tsp_pkg::STEP_MS;

  assign cfg_halt = cfg_i.en && (cfg_i.index == tsp_pkg::CFG_ENABLED) && !cfg_i.data[0];

  always_comb begin
    idx_d     = idx_q;
    len_d     = len_q;
    rep_d     = rep_q;
    active_d  = active_q;
    elapsed_d = elapsed_q;
    hz_d      = hz_q;
    on_d      = on_q;
    tc_d      = tc_q;
    tbl_wr_o  = '{en: 1'b0, idx: req_i.entry_index,
                  data: {req_i.tone_frequency_code, req_i.tone_time_code}};

    if (fire_i) begin
      unique case (req_i.operation)
        tsp_pkg::OP_TICK: begin
          if (active_q) begin
            elapsed_d = el_inc;
            if (tc_q != tsp_pkg::HOLD_CODE && el_inc >= limit) begin
              if (wrap && !rep_q) begin
                // end of list: park on the last entry and go silent
                idx_d    = (len_q != '0) ? len_q - tsp_pkg::COUNT_W'(1) : '0;
                on_d     = 1'b0;
                active_d = 1'b0;
              end else begin
                idx_d     = tbl_rd_idx_o;
                elapsed_d = '0;
                tc_d      = tbl_rd_data_i[tsp_pkg::CODE_W-1:0];
                if (tbl_rd_data_i[tsp_pkg::ENTRY_W-1 -: tsp_pkg::CODE_W] == '0) begin
                  on_d = 1'b0;
                end else begin
                  hz_d = tsp_pkg::HZ_W'(tbl_rd_data_i[tsp_pkg::ENTRY_W-1 -: tsp_pkg::CODE_W])
                       * tsp_pkg::HZ_W'(next_scale_q);
                  on_d = 1'b1;
                end
              end
            end
          end
        end
        tsp_pkg::OP_WRITE: begin
          tbl_wr_o.en = 1'b1;
          // keep the sounding time code in step with the table
          if ({1'b0, req_i.entry_index} == idx_q) begin
            tc_d = req_i.tone_time_code;
          end
        end
        tsp_pkg::OP_PLAY: begin
          if (enabled_q) begin
            if (req_i.tone_count == '0) begin
              on_d     = 1'b0;
              active_d = 1'b0;
            end else begin
              len_d     = (32'(req_i.tone_count) > TABLE_DEPTH)
                          ? tsp_pkg::COUNT_W'(TABLE_DEPTH) : req_i.tone_count;
              rep_d     = req_i.repeat_flag;
              idx_d     = '0;
              elapsed_d = '0;
              active_d  = 1'b1;
              tc_d      = tbl_entry0_i[tsp_pkg::CODE_W-1:0];
              if (tbl_entry0_i[tsp_pkg::ENTRY_W-1 -: tsp_pkg::CODE_W] == '0) begin
                on_d = 1'b0;
              end else begin
                hz_d = tsp_pkg::HZ_W'(tbl_entry0_i[tsp_pkg::ENTRY_W-1 -: tsp_pkg::CODE_W])
                     * tsp_pkg::HZ_W'(first_scale_q);
                on_d = 1'b1;
              end
            end
          end
        end
        tsp_pkg::OP_STOP: begin
          on_d     = 1'b0;
          active_d = 1'b0;
        end
        default: begin
          on_d = on_q;
        end
      endcase
    end

    // disabling acts as a stop
    if (cfg_halt) begin
      on_d     = 1'b0;
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q     <= 1'b1;
      first_scale_q <= tsp_pkg::FIRST_SCALE_RST;
      next_scale_q  <= tsp_pkg::NEXT_SCALE_RST;
    end else if (cfg_i.en) begin
      unique case (cfg_i.index)
        tsp_pkg::CFG_ENABLED:     enabled_q     <= cfg_i.data[0];
        tsp_pkg::CFG_FIRST_SCALE: first_scale_q <= cfg_i.data;
        tsp_pkg::CFG_NEXT_SCALE:  next_scale_q  <= cfg_i.data;
        default:                  enabled_q     <= enabled_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      len_q     <= '0;
      rep_q     <= 1'b0;
      active_q  <= 1'b0;
      elapsed_q <= '0;
      hz_q      <= '0;
      on_q      <= 1'b0;
      tc_q      <= '0;
    end else begin
      idx_q     <= idx_d;
      len_q     <= len_d;
      rep_q     <= rep_d;
      active_q  <= active_d;
      elapsed_q <= elapsed_d;
      hz_q      <= hz_d;
      on_q      <= on_d;
      tc_q      <= tc_d;
    end
  end

  assign res_o = '{tone_hz: hz_d, sound_on: on_d, playing: active_d,
                   tone_position: idx_d[tsp_pkg::IDX_W-1:0]};

endmodule

### hdl/tone_sequence_player.sv
// Channel   Direction  Handshake                 Payload
// in        request    in_valid_i / in_stall_o    in_req_i   (tsp_pkg::tsp_in_t)
// out       result     out_valid_o / out_stall_i  out_res_o  (tsp_pkg::tsp_out_t)
// cfg       write      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle unless in_stall_o holds it; each request passes through
// the request register, then the result register. The state update of a request
// lands in the same edge as its result, so the next request sees it at once.
// Reset clears the player state and loads the scales (60, 75) and enable (1);
// the tone table is not cleared. A stalled result holds in the result register
// while one more request is taken into the request register.
module tone_sequence_player #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  tsp_pkg::tsp_in_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tsp_pkg::tsp_out_t          out_res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [tsp_pkg::CODE_W-1:0] cfg_data_i
);

  logic                         req_valid_q;
  tsp_pkg::tsp_in_t             req_q;
  logic                         res_valid_q;
  tsp_pkg::tsp_out_t            res_q;
  tsp_pkg::tsp_out_t            res_d;
  logic                         fire;
  tsp_pkg::tsp_cfg_wr_t         cfg_wr;
  tsp_pkg::tsp_tbl_wr_t         tbl_wr;
  logic [tsp_pkg::COUNT_W-1:0]  tbl_rd_idx;
  logic [tsp_pkg::ENTRY_W-1:0]  tbl_rd_data;
  logic [tsp_pkg::ENTRY_W-1:0]  tbl_entry0;

  // process the held request when the result register is free or draining
  assign fire       = req_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = '{en: cfg_valid_i, index: cfg_index_i, data: cfg_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

  tsp_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .wr_i     (tbl_wr),
    .rd_idx_i (tbl_rd_idx),
    .rd_data_o(tbl_rd_data),
    .entry0_o (tbl_entry0)
  );

  tsp_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .req_i         (req_q),
    .cfg_i         (cfg_wr),
    .tbl_rd_data_i (tbl_rd_data),
    .tbl_entry0_i  (tbl_entry0),
    .tbl_rd_idx_o  (tbl_rd_idx),
    .tbl_wr_o      (tbl_wr),
    .res_o         (res_d)
  );

`ifndef NO_ASSERTIONS
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_valid_q)
    else $error("processed request produced no result");

  a_stall_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req_valid_q)
    else $error("input stalled with no request held");

  a_blocked_request_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !fire) |=> (req_valid_q && $stable(req_q)))
    else $error("blocked request lost or changed");
`endif

endmodule
